/* hw/rtl/crs_pkg.sv */
// Shared types, constants and helpers for the Catmull-Rom curve point block.
// No dependencies.
`default_nettype none
package crs_pkg;

    localparam int CW = 38;
    localparam int PW = CW + 18;

    localparam logic [1:0] MODE_ZERO  = 2'd0;
    localparam logic [1:0] MODE_ONE   = 2'd1;
    localparam logic [1:0] MODE_CURVE = 2'd2;

    typedef logic signed [CW-1:0] acc_t;
    typedef logic signed [PW-1:0] prod_t;

    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

    localparam acc_t SAT_HI = acc_t'(64'sd2147483647);
    localparam acc_t SAT_LO = acc_t'(-64'sd2147483648);

    // round half up of a Q16 product back to integer scale
    function automatic acc_t rnd_q16(input prod_t v);
        prod_t s;
        s = v + PW'(32768);
        return acc_t'(s >>> 16);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/crs_store.sv */
// Control point store: four copies, one read port each, read data registered.
// Depends on crs_pkg.
`default_nettype none
module crs_store
    import crs_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int AW = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  wen,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [95:0]           wdata,
    input  wire logic                  ren,
    input  wire logic [3:0][AW-1:0]    raddr,
    output      logic [3:0][95:0]      rdata
);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [95:0] mem [MAX_POINTS];
        logic [95:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (wen)
            begin
                mem[waddr] <= wdata;
            end
            if (ren)
            begin
                rd_reg <= mem[raddr[b]];
            end
        end

        assign rdata[b] = rd_reg;
    end

endmodule
`default_nettype wire

/* hw/rtl/crs_horner.sv */
// One coordinate axis: coefficients, three Horner steps, round and saturate; mode may pick p1 or zero.
// Depends on crs_pkg.
`default_nettype none
module crs_horner
    import crs_pkg::*;
(
    input  wire logic                clk,
    input  wire stage_en_t           en,
    input  wire logic signed [31:0]  p0,
    input  wire logic signed [31:0]  p1,
    input  wire logic signed [31:0]  p2,
    input  wire logic signed [31:0]  p3,
    input  wire logic [16:0]         u,
    input  wire logic [1:0]          mode,
    output      logic [31:0]         result
);

    acc_t e0, e1, e2, e3;
    acc_t c3_reg, c2_reg, c1_reg, tp1_3_reg;
    acc_t a1_reg, c1_4_reg, tp1_4_reg;
    acc_t a2_reg, tp1_5_reg;
    logic [16:0] u3_reg, u4_reg, u5_reg;
    logic [1:0] m3_reg, m4_reg, m5_reg;
    logic [31:0] q3_reg, q4_reg, q5_reg;
    logic [31:0] res_reg;
    prod_t pr4, pr5, pr6;
    acc_t a3, half;
    logic [31:0] res_next;

    assign e0 = acc_t'(p0);
    assign e1 = acc_t'(p1);
    assign e2 = acc_t'(p2);
    assign e3 = acc_t'(p3);

    assign pr4 = c3_reg * $signed({1'b0, u3_reg});
    assign pr5 = a1_reg * $signed({1'b0, u4_reg});
    assign pr6 = a2_reg * $signed({1'b0, u5_reg});
    assign a3 = tp1_5_reg + rnd_q16(pr6);
    assign half = (a3 + acc_t'(1)) >>> 1;

    always_comb
    begin
        res_next = 32'd0;
        case (m5_reg)
            MODE_ONE:   res_next = q5_reg;
            MODE_CURVE:
            begin
                if (half > SAT_HI)
                    res_next = 32'h7fff_ffff;
                else if (half < SAT_LO)
                    res_next = 32'h8000_0000;
                else
                    res_next = half[31:0];
            end
            default:    res_next = 32'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            c3_reg    <= e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
            c2_reg    <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
            c1_reg    <= e2 - e0;
            tp1_3_reg <= e1 <<< 1;
            u3_reg    <= u;
            m3_reg    <= mode;
            q3_reg    <= p1;
        end
        if (en.s4)
        begin
            a1_reg    <= c2_reg + rnd_q16(pr4);
            c1_4_reg  <= c1_reg;
            tp1_4_reg <= tp1_3_reg;
            u4_reg    <= u3_reg;
            m4_reg    <= m3_reg;
            q4_reg    <= q3_reg;
        end
        if (en.s5)
        begin
            a2_reg    <= c1_4_reg + rnd_q16(pr5);
            tp1_5_reg <= tp1_4_reg;
            u5_reg    <= u4_reg;
            m5_reg    <= m4_reg;
            q5_reg    <= q4_reg;
        end
        if (en.s6)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule
`default_nettype wire

/* hw/rtl/catmull_rom_spline_point_top.sv */
// Catmull-Rom curve point block: six-stage pipeline, one beat per cycle while the output is not stalled.
// Throughput 1 beat per cycle unless m_axis_tready stalls the output.
// Stages: input reg, point store read, coefficients, three Horner multiply steps.
// A point write takes effect for every evaluate beat that follows it.
// Reset clears valid bits and point_count; the point store is not cleared.
// Depends on crs_pkg, crs_store, crs_horner.
`default_nettype none
module catmull_rom_spline_point_top
    import crs_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output      logic [31:0]   prdata,
    output      logic          pready,
    input  wire logic          s_axis_tvalid,
    output      logic          s_axis_tready,
    // point_index[5:0], point_x[37:6], point_y[69:38], point_z[101:70], curve_t[118:102]
    input  wire logic [119:0]  s_axis_tdata,
    // command[0]
    input  wire logic          s_axis_tuser,
    output      logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // curve_x[31:0], curve_y[63:32], curve_z[95:64]
    output      logic [95:0]   m_axis_tdata
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [6:0] count_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2;
    stage_en_t en;

    logic        cmd_reg;
    logic [5:0]  slot_reg;
    logic [95:0] pt_reg;
    logic [16:0] t_reg;
    logic [16:0] u2_reg;
    logic [1:0]  m2_reg;

    logic [6:0]  n, nm1, idx, i0, i2, i3;
    logic [16:0] tc, u;
    logic [23:0] prod;
    logic [1:0]  mode;
    logic [3:0][AW-1:0] raddr;
    logic [3:0][95:0] rdata;
    logic wen;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {25'd0, count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 7'd0;
        end
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
        begin
            count_reg <= pwdata[6:0];
        end
    end

    // stage enables
    assign en.s6 = !v6_reg || m_axis_tready;
    assign en.s5 = !v5_reg || en.s6;
    assign en.s4 = !v4_reg || en.s5;
    assign en.s3 = !v3_reg || en.s4;
    assign en2   = !v2_reg || en.s3;
    assign en1   = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1)   v1_reg <= s_axis_tvalid;
            if (en2)   v2_reg <= v1_reg && cmd_reg;
            if (en.s3) v3_reg <= v2_reg;
            if (en.s4) v4_reg <= v3_reg;
            if (en.s5) v5_reg <= v4_reg;
            if (en.s6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            cmd_reg  <= s_axis_tuser;
            slot_reg <= s_axis_tdata[5:0];
            pt_reg   <= s_axis_tdata[101:6];
            t_reg    <= s_axis_tdata[118:102];
        end
        if (en2)
        begin
            u2_reg <= u;
            m2_reg <= mode;
        end
    end

    // segment select
    always_comb
    begin
        n    = (int'(count_reg) > MAX_POINTS) ? 7'(MAX_POINTS) : count_reg;
        nm1  = n - 7'd1;
        tc   = (t_reg > 17'd65536) ? 17'd65536 : t_reg;
        prod = 24'(tc) * 24'(nm1);
        idx  = prod[22:16];
        u    = {1'b0, prod[15:0]};
        if (prod[23:16] >= {1'b0, nm1})
        begin
            idx = n - 7'd2;
            u   = 17'd65536;
        end
        i0 = (idx == 7'd0) ? 7'd0 : idx - 7'd1;
        i2 = idx + 7'd1;
        i3 = (idx + 7'd2 > nm1) ? nm1 : idx + 7'd2;
        if (n == 7'd0)
            mode = MODE_ZERO;
        else if (n == 7'd1)
            mode = MODE_ONE;
        else
            mode = MODE_CURVE;
        if (n < 7'd2)
        begin
            i0  = 7'd0;
            idx = 7'd0;
            i2  = 7'd0;
            i3  = 7'd0;
        end
        raddr[0] = AW'(i0);
        raddr[1] = AW'(idx);
        raddr[2] = AW'(i2);
        raddr[3] = AW'(i3);
    end

    assign wen = v1_reg && !cmd_reg && en2 && (int'(slot_reg) < MAX_POINTS);

    crs_store #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_store (
        .clk   (clk),
        .wen   (wen),
        .waddr (AW'(slot_reg)),
        .wdata (pt_reg),
        .ren   (en2),
        .raddr (raddr),
        .rdata (rdata)
    );

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        crs_horner u_axis (
            .clk    (clk),
            .en     (en),
            .p0     ($signed(rdata[0][32*a +: 32])),
            .p1     ($signed(rdata[1][32*a +: 32])),
            .p2     ($signed(rdata[2][32*a +: 32])),
            .p3     ($signed(rdata[3][32*a +: 32])),
            .u      (u2_reg),
            .mode   (m2_reg),
            .result (m_axis_tdata[32*a +: 32])
        );
    end

    assign m_axis_tvalid = v6_reg;

endmodule
`default_nettype wire

/* hw/rtl/crs_checker.sv */
// Port-level checks for the Catmull-Rom curve point block, bound to the top.
// Depends on catmull_rom_spline_point_top.
`default_nettype none
module crs_checker
(
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          psel,
    input wire logic          penable,
    input wire logic          pwrite,
    input wire logic [2:0]    paddr,
    input wire logic [31:0]   pwdata,
    input wire logic [31:0]   prdata,
    input wire logic          s_axis_tready,
    input wire logic          m_axis_tvalid,
    input wire logic          m_axis_tready,
    input wire logic [95:0]   m_axis_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed under stall");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    a_count_rd: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == 1'b0
        |=> paddr[2] != 1'b0 || prdata[6:0] == $past(pwdata[6:0]))
        else $error("point_count readback mismatch");

endmodule

bind catmull_rom_spline_point_top crs_checker u_crs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
